[rtl/dsfc_pkg.sv]
// Package for the binary64 to binary32 converter.
// Holds format constants and the conversion function; no dependencies.
package dsfc_pkg;
  localparam logic [10:0] EXP_ONES_D = 11'h7FF;
  localparam logic [31:0] INF_S = 32'h7F80_0000;

  // Round-to-nearest-even right shift of a 53-bit significand, sh in 1..53.
  function automatic logic [52:0] round_shift(input logic [52:0] sig, input logic [5:0] sh);
    logic [52:0] q;
    logic [52:0] msk;
    logic [52:0] rem;
    logic [52:0] half;
    logic        up;
    q    = sig >> sh;
    msk  = ~(53'h1F_FFFF_FFFF_FFFF << sh);
    rem  = sig & msk;
    half = 53'h1 << (sh - 6'd1);
    up   = (rem > half) || ((rem == half) && q[0]);
    return q + {52'd0, up};
  endfunction

  function automatic logic [31:0] convert(input logic [63:0] d);
    logic        s;
    logic [10:0] ef;
    logic [52:0] sig;
    logic [52:0] q;
    logic [31:0] mag;
    logic [10:0] sh;
    convert = 32'd0;
    s   = d[63];
    ef  = d[62:52];
    sig = {1'b1, d[51:0]};
    q   = round_shift(sig, 6'd29);
    // sh = 29 + (897 - ef) for ef below 897
    sh  = 11'd926 - ef;
    if (ef == 11'd0) begin
      convert = 32'd0;
    end else if (ef == EXP_ONES_D || ef > 11'd1150) begin
      convert = {s, INF_S[30:0]};
    end else if (ef >= 11'd897) begin
      // exponent field of result: ef - 896 - 1, plus carry from hidden bit
      mag = {1'b0, 8'(ef - 11'd897), 23'd0} + q[31:0];
      if (mag >= INF_S) mag = INF_S;
      convert = {s, mag[30:0]};
    end else if (sh >= 11'd54) begin
      convert = {s, 31'd0};
    end else begin
      q = round_shift(sig, sh[5:0]);
      convert = {s, q[30:0]};
    end
  endfunction
endpackage

[rtl/double_to_single_float_convert.sv]
// Top level of the binary64 to binary32 converter.
// Depends on dsfc_pkg for the conversion function.
//
// Input channel: in_valid/in_stall with double_bits. Output channel:
// out_valid/out_stall with single_bits. A beat is taken when valid is
// high and stall is low. The input word is registered at the accepting
// edge, converted by combinational logic and loaded into the result
// register when the result stage advances; throughput is one word per
// cycle while the output is not stalled. The input
// and result stages advance together whenever the result stage is empty or
// being taken, so a stall on the output backs up into in_stall only when
// both stages hold data. Reset clears both valid flags; no word survives.
module double_to_single_float_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] double_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] single_bits
);
  logic        v1;
  logic [63:0] d1;
  logic        adv2;
  logic        adv1;

  assign adv2     = !out_valid || !out_stall;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) out_valid <= v1;
    end
    if (adv1 && in_valid) d1 <= double_bits;
    if (adv2 && v1) single_bits <= dsfc_pkg::convert(d1);
  end
endmodule

[rtl/dsfc_checker.sv]
// Port-level checks for the converter, bound to the top level.
// Depends on nothing but the top-level ports.
module dsfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] single_bits
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(single_bits))
    else $error("result dropped under stall");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !$past(in_valid) && !$past(in_valid, 2) && !$past(out_valid) |-> !out_valid)
    else $error("result without input");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("stall with empty output");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind double_to_single_float_convert dsfc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .single_bits(single_bits)
);
